### hw/rtl/scc_pkg.sv
// Shared types and constants for the sector cache tag and policy controller.
`default_nettype none
package scc_pkg;

  // Request codes as they arrive on the input stream
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Stream widths, padded to whole bytes
  localparam int IN_W  = 40;
  localparam int OUT_W = 48;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_FLUSH,
    OP_NOP
  } op_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] sector;
  } req_t;

  // One result item
  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        fill;
    logic        wb;
    logic [31:0] wb_sector;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVSCAN,
    ST_EVTAG,
    ST_EVWB,
    ST_SHIFT,
    ST_INSERT,
    ST_FLSCAN,
    ST_FLTAG,
    ST_FLGOT,
    ST_FLEND,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/scc_front.sv
// Front end: input transfer, request classification and a two-entry request queue.
`default_nettype none
module scc_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [scc_pkg::IN_W-1:0] s_tdata,  // [1:0] func, [33:2] sector
  output scc_pkg::req_t                 req,
  output logic                          req_valid,
  input  wire logic                     req_pop
);
  import scc_pkg::*;

  req_t       q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  req_t       in_req;
  logic       push;

  // Classify the incoming code
  always_comb begin
    in_req.sector = s_tdata[33:2];
    unique case (s_tdata[1:0])
      FUNC_READ:  in_req.op = OP_READ;
      FUNC_WRITE: in_req.op = OP_WRITE;
      FUNC_FLUSH: in_req.op = OP_FLUSH;
      default:    in_req.op = OP_NOP;
    endcase
  end

  assign s_tready  = (fill != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign req_valid = (fill != 2'd0);
  assign req       = q_data[rd_ptr];

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (req_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, req_pop};
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_data[wr_ptr] <= in_req;
  end

endmodule
`default_nettype wire

### hw/rtl/scc_back.sv
// Back end: tag and order memories, lookup, clock eviction, flush and result register.
`default_nettype none
module scc_back #(
  parameter int CAPACITY    = 64,
  parameter int SECTOR_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  scc_pkg::req_t      req,
  input  wire logic          req_valid,
  output logic               req_pop,
  output scc_pkg::res_t      out_res,
  output logic               out_valid,
  input  wire logic          out_ready
);
  import scc_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (SECTOR_BITS < 32) ? SECTOR_BITS : 32;
  localparam int RW = $bits(res_t);

  // Memories
  logic [TW-1:0] tag_mem [CAPACITY];
  logic [SW-1:0] age_mem [CAPACITY];
  logic [TW-1:0] tag_rdata;
  logic [SW-1:0] age_rdata;
  logic [SW-1:0] tag_raddr, tag_waddr, age_raddr, age_waddr;
  logic [SW-1:0] age_wdata;
  logic          tag_we, age_we;

  // Control and per-slot marks
  state_t        state, state_next;
  logic [CAPACITY-1:0] valid, dirty, accessed;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          chk;
  logic [SW-1:0] chk_idx;
  logic          free_found;
  logic          pend;

  // Payload registers
  op_t           op;
  logic [TW-1:0] sec;
  logic [SW-1:0] free_slot;
  logic [SW-1:0] vs;
  logic [SW-1:0] vpos;
  logic [SW-1:0] ins_slot;
  logic          wb;
  logic [31:0]   wb_sec;
  res_t          res;
  res_t          pend_res;

  logic out_free, full, out_set;
  logic lk_issue, lk_hit, lk_miss;
  logic ev_found;
  logic sh_issue, sh_done;
  logic fl_issue, fl_found, fl_done;
  res_t fl_new;

  assign out_free = !out_valid || out_ready;
  assign full     = (count == CW'(CAPACITY));

  assign lk_issue = (idx < CW'(CAPACITY));
  assign lk_hit   = chk && valid[chk_idx] && (tag_rdata == sec);
  assign lk_miss  = chk && !lk_hit && (chk_idx == SW'(CAPACITY - 1));
  assign ev_found = chk && !accessed[age_rdata];
  assign sh_issue = (idx < count);
  assign sh_done  = !sh_issue && !chk;
  assign fl_issue = (idx < count);
  assign fl_found = chk && dirty[age_rdata];
  assign fl_done  = !fl_issue && !chk;

  // A new result enters the output register
  assign out_set = out_free && (((state == ST_FLGOT) && pend) ||
                                (state == ST_FLEND) || (state == ST_EMIT));

  always_comb begin
    fl_new.hit       = 1'b0;
    fl_new.slot      = 6'(vs);
    fl_new.fill      = 1'b0;
    fl_new.wb        = 1'b1;
    fl_new.wb_sector = 32'(tag_rdata);
    fl_new.last      = 1'b0;
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= sec;
    tag_rdata <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_waddr] <= age_wdata;
    age_rdata <= age_mem[age_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and memory strobes
  always_comb begin
    state_next = state;
    req_pop    = 1'b0;
    tag_raddr  = idx[SW-1:0];
    age_raddr  = idx[SW-1:0];
    tag_we     = 1'b0;
    tag_waddr  = ins_slot;
    age_we     = 1'b0;
    age_waddr  = chk_idx - 1'b1;
    age_wdata  = age_rdata;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          unique case (req.op) inside
            OP_READ, OP_WRITE: state_next = ST_LOOK;
            OP_FLUSH:          state_next = ST_FLSCAN;
            default:           state_next = ST_EMIT;
          endcase
        end
      end
      ST_LOOK: begin
        if (lk_hit) state_next = ST_EMIT;
        else if (lk_miss) state_next = full ? ST_EVSCAN : ST_INSERT;
      end
      ST_EVSCAN: if (ev_found) state_next = ST_EVTAG;
      ST_EVTAG: begin
        tag_raddr  = vs;
        state_next = ST_EVWB;
      end
      ST_EVWB: begin
        tag_raddr  = vs;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        age_we = chk;
        if (sh_done) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        tag_we     = 1'b1;
        age_we     = 1'b1;
        age_waddr  = full ? SW'(CAPACITY - 1) : count[SW-1:0];
        age_wdata  = ins_slot;
        state_next = ST_EMIT;
      end
      ST_FLSCAN: begin
        if (fl_found) state_next = ST_FLTAG;
        else if (fl_done) state_next = ST_FLEND;
      end
      ST_FLTAG: begin
        tag_raddr  = vs;
        state_next = ST_FLGOT;
      end
      ST_FLGOT: begin
        tag_raddr = vs;
        if (!pend || out_free) state_next = ST_FLSCAN;
      end
      ST_FLEND: if (out_free) state_next = ST_IDLE;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // Control registers and marks
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      dirty      <= '0;
      accessed   <= '0;
      count      <= '0;
      idx        <= '0;
      chk        <= 1'b0;
      free_found <= 1'b0;
      pend       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx        <= '0;
          chk        <= 1'b0;
          free_found <= 1'b0;
          pend       <= 1'b0;
        end
        ST_LOOK: begin
          if (lk_miss) begin
            idx <= '0;
            chk <= 1'b0;
          end else begin
            chk <= lk_issue;
            if (lk_issue) idx <= idx + 1'b1;
          end
          if (chk && !valid[chk_idx] && !free_found) free_found <= 1'b1;
          if (lk_hit) begin
            accessed[chk_idx] <= 1'b1;
            if (op == OP_WRITE) dirty[chk_idx] <= 1'b1;
          end
        end
        ST_EVSCAN: begin
          // Second chance: clear set marks while walking oldest first
          chk <= 1'b1;
          idx <= (idx == CW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
          if (chk && accessed[age_rdata]) accessed[age_rdata] <= 1'b0;
        end
        ST_EVWB: begin
          valid[vs]    <= 1'b0;
          dirty[vs]    <= 1'b0;
          accessed[vs] <= 1'b0;
          idx          <= CW'(vpos) + 1'b1;
          chk          <= 1'b0;
        end
        ST_SHIFT: begin
          chk <= sh_issue;
          if (sh_issue) idx <= idx + 1'b1;
        end
        ST_INSERT: begin
          valid[ins_slot]    <= 1'b1;
          accessed[ins_slot] <= 1'b1;
          dirty[ins_slot]    <= (op == OP_WRITE);
          if (!full) count <= count + 1'b1;
        end
        ST_FLSCAN: begin
          if (fl_found) begin
            idx <= CW'(chk_idx) + 1'b1;
            chk <= 1'b0;
          end else begin
            chk <= fl_issue;
            if (fl_issue) idx <= idx + 1'b1;
          end
        end
        ST_FLGOT: begin
          if (!pend) pend <= 1'b1;
        end
        ST_FLEND: begin
          if (out_free) begin
            valid     <= '0;
            dirty     <= '0;
            accessed  <= '0;
            count     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op  <= req.op;
        sec <= req.sector[TW-1:0];
        wb  <= 1'b0;
        wb_sec <= '0;
        res <= res_t'({{(RW-1){1'b0}}, 1'b1});
      end
      ST_LOOK: begin
        if (lk_issue) chk_idx <= idx[SW-1:0];
        if (chk && !valid[chk_idx] && !free_found) free_slot <= chk_idx;
        if (lk_hit) begin
          res.hit  <= 1'b1;
          res.slot <= 6'(chk_idx);
        end
        if (lk_miss) ins_slot <= free_found ? free_slot : chk_idx;
      end
      ST_EVSCAN: begin
        chk_idx <= idx[SW-1:0];
        if (ev_found) begin
          vs   <= age_rdata;
          vpos <= chk_idx;
        end
      end
      ST_EVWB: begin
        ins_slot <= vs;
        wb       <= dirty[vs];
        wb_sec   <= dirty[vs] ? 32'(tag_rdata) : 32'd0;
      end
      ST_SHIFT: if (sh_issue) chk_idx <= idx[SW-1:0];
      ST_INSERT: begin
        res.hit       <= 1'b0;
        res.slot      <= 6'(ins_slot);
        res.fill      <= (op == OP_READ);
        res.wb        <= wb;
        res.wb_sector <= wb_sec;
        res.last      <= 1'b1;
      end
      ST_FLSCAN: begin
        if (fl_issue) chk_idx <= idx[SW-1:0];
        if (fl_found) vs <= age_rdata;
      end
      ST_FLGOT: if (!pend || out_free) pend_res <= fl_new;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    unique case (state)
      ST_FLGOT: if (pend && out_free) out_res <= pend_res;
      ST_FLEND: begin
        if (out_free) begin
          if (pend) begin
            out_res <= res_t'({pend_res[RW-1:1], 1'b1});
          end else begin
            out_res <= res;
          end
        end
      end
      ST_EMIT: if (out_free) out_res <= res;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/sector_cache_clock_replacement.sv
// Top level of the sector cache tag and policy controller.
// Requests enter on the s_ group (func read, write or flush, and a sector
// number); results leave on the m_ group, tlast marking the final result of
// a request. A two-entry queue decouples request intake from the engine,
// and a result register lets the engine finish while the receiver stalls.
// Work per request, with one memory read port used per step:
//   read or write hit: tag lookup over the slots until a match
//   miss, cache not full: tag lookup over every slot, then insertion
//   miss, cache full: adds the clock scan over the order memory, a read
//     of the victim tag and a shift of the order memory to close the gap
//   flush: a scan over the entries; one result per dirty entry, the last
//     of them marked final, or a single empty result if none is dirty
// One request is worked on at a time; the next may sit in the queue.
// Reset empties the cache at once: marks and entry count clear, memories
// keep stale contents that are never read. A stalled receiver holds the
// current result and the engine waits before producing the next one.
`default_nettype none
module sector_cache_clock_replacement #(
  parameter int CAPACITY    = 64,
  parameter int SECTOR_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [scc_pkg::IN_W-1:0]  s_tdata,   // [1:0] func, [33:2] sector
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [scc_pkg::OUT_W-1:0]      m_tdata,   // [0] hit, [6:1] slot, [7] fill_needed,
                                                    // [8] writeback_needed,
                                                    // [40:9] writeback_sector
  output logic                           m_tlast
);
  import scc_pkg::*;

  req_t req;
  logic req_valid;
  logic req_pop;
  res_t out_res;

  scc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .req       (req),
    .req_valid (req_valid),
    .req_pop   (req_pop)
  );

  scc_back #(
    .CAPACITY    (CAPACITY),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .out_res   (out_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  // Pack the result fields
  assign m_tdata = {7'd0, out_res.wb_sector, out_res.wb, out_res.fill,
                    out_res.slot, out_res.hit};
  assign m_tlast = out_res.last;

endmodule
`default_nettype wire

### sim/sector_cache_clock_replacement_tb.sv
// Self-checking testbench for the sector cache tag and clock replacement controller.
`default_nettype none
module sector_cache_clock_replacement_tb;
  import scc_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;

  sector_cache_clock_replacement uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the cache directory
  logic [31:0] tag_mirror[SLOTS];
  bit          valid_mirror[SLOTS];
  bit          dirty_mirror[SLOTS];
  bit          accessed_mirror[SLOTS];
  logic [5:0]  age_mirror[SLOTS];
  int          resident;

  res_t fresh_replies[$];
  res_t cache_replies[$];

  int errors = 0;
  int replies_seen = 0;
  int hit_count = 0, evict_count = 0, writeback_count = 0, flush_count = 0;
  bit hold_requested = 1'b0;
  bit steady_run = 1'b0;
  int idle_cycles = 0;

  // Work out the replies of one request and update the mirror
  task automatic predict_cache_access(input logic [1:0] func, input logic [31:0] sector);
    res_t r;
    int pos, steps, n, slot, k, found;
    logic [5:0] s;
    r = '0;
    r.last = 1'b1;
    if (func == FUNC_FLUSH) begin
      flush_count++;
      k = 0;
      for (int i = 0; i < resident; i++) begin
        s = age_mirror[i];
        if (valid_mirror[s] && dirty_mirror[s]) begin
          r = '0;
          r.slot = s;
          r.wb = 1'b1;
          r.wb_sector = tag_mirror[s];
          fresh_replies.push_back(r);
          writeback_count++;
          k++;
        end
      end
      if (k == 0) begin
        r = '0;
        fresh_replies.push_back(r);
      end
      fresh_replies[fresh_replies.size()-1].last = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        valid_mirror[i] = 0;
        dirty_mirror[i] = 0;
        accessed_mirror[i] = 0;
      end
      resident = 0;
    end else if (func == FUNC_UNKNOWN) begin
      fresh_replies.push_back(r);
    end else begin
      found = 0;
      for (int i = 0; i < resident && !found; i++) begin
        s = age_mirror[i];
        if (valid_mirror[s] && tag_mirror[s] == sector) begin
          accessed_mirror[s] = 1;
          if (func == FUNC_WRITE) dirty_mirror[s] = 1;
          r.hit = 1'b1;
          r.slot = s;
          found = 1;
          hit_count++;
        end
      end
      if (!found) begin
        // Clock scan for a victim when every slot is taken
        if (resident >= SLOTS) begin
          pos = 0;
          n = resident;
          for (steps = 0; steps <= 2 * n; steps++) begin
            s = age_mirror[pos];
            if (accessed_mirror[s]) begin
              accessed_mirror[s] = 0;
            end else begin
              if (dirty_mirror[s]) begin
                r.wb = 1'b1;
                r.wb_sector = tag_mirror[s];
                writeback_count++;
              end
              valid_mirror[s] = 0;
              dirty_mirror[s] = 0;
              for (int i = pos; i + 1 < resident; i++) age_mirror[i] = age_mirror[i+1];
              resident--;
              evict_count++;
              break;
            end
            pos++;
            if (pos >= n) pos = 0;
          end
        end
        slot = 0;
        while (slot < SLOTS && valid_mirror[slot]) slot++;
        tag_mirror[slot] = sector;
        valid_mirror[slot] = 1;
        dirty_mirror[slot] = (func == FUNC_WRITE);
        accessed_mirror[slot] = 1;
        age_mirror[resident] = slot[5:0];
        resident++;
        r.slot = slot[5:0];
        r.fill = (func == FUNC_READ);
      end
      fresh_replies.push_back(r);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, wait for its transfer, then idle for a random gap, possibly none
  task automatic send_request(input logic [1:0] func, input logic [31:0] sector,
                              input bit typed, input res_t typed_reply);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, sector, func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_cache_access(func, sector);
    if (typed) begin
      cache_replies.push_back(typed_reply);
      fresh_replies.delete();
    end else begin
      while (fresh_replies.size() > 0) cache_replies.push_back(fresh_replies.pop_front());
    end
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Receiver readiness, with one long hold-off
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_requested && !held) begin
        held = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = gap_len();
        m_tready <= (stall_left == 0);
      end
    end
  end

  // Result check
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit = m_tdata[0];
      got.slot = m_tdata[6:1];
      got.fill = m_tdata[7];
      got.wb = m_tdata[8];
      got.wb_sector = m_tdata[40:9];
      got.last = m_tlast;
      replies_seen++;
      if (cache_replies.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = cache_replies.pop_front();
        if (got.hit != want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.slot != want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
          errors++;
        end
        if (got.fill != want.fill) begin
          $display("%0t: fill_needed expected %0d actual %0d", $time, want.fill, got.fill);
          errors++;
        end
        if (got.wb != want.wb) begin
          $display("%0t: writeback_needed expected %0d actual %0d", $time, want.wb, got.wb);
          errors++;
        end
        if (got.wb_sector != want.wb_sector) begin
          $display("%0t: writeback_sector expected %h actual %h", $time,
                   want.wb_sector, got.wb_sector);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, cache_replies.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  typedef struct {
    logic [1:0]  func;
    logic [31:0] sector;
    bit          typed;
    res_t        reply;
  } stim_row_t;

  // Directed requests; typed replies only where obvious
  localparam int N_ROWS = 13;
  stim_row_t stim_rows[N_ROWS] = '{
    '{FUNC_FLUSH,   32'h0,        1, '{1'b0, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{FUNC_UNKNOWN, 32'hFFFFFFFF, 1, '{1'b0, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{FUNC_READ,    32'h0,        1, '{1'b0, 6'd0, 1'b1, 1'b0, 32'h0, 1'b1}},
    '{FUNC_WRITE,   32'hFFFFFFFF, 1, '{1'b0, 6'd1, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{FUNC_READ,    32'hFFFFFFFF, 1, '{1'b1, 6'd1, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{FUNC_WRITE,   32'h0,        1, '{1'b1, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}},
    '{FUNC_READ,    32'hAAAAAAAA, 0, '0},
    '{FUNC_WRITE,   32'h55555555, 0, '0},
    '{FUNC_WRITE,   32'h80000000, 0, '0},
    '{FUNC_READ,    32'h00000001, 0, '0},
    '{FUNC_UNKNOWN, 32'h0,        0, '0},
    '{FUNC_FLUSH,   32'hFFFFFFFF, 0, '0},
    '{FUNC_READ,    32'h0,        1, '{1'b0, 6'd0, 1'b1, 1'b0, 32'h0, 1'b1}}
  };

  initial begin
    logic [31:0] sector_pool[96];
    logic [1:0] func;
    logic [31:0] sector;
    int r, settle;
    for (int i = 0; i < SLOTS; i++) begin
      valid_mirror[i] = 0;
      dirty_mirror[i] = 0;
      accessed_mirror[i] = 0;
    end
    resident = 0;
    for (int i = 0; i < 96; i++) sector_pool[i] = $urandom();
    sector_pool[0] = 32'h0;
    sector_pool[1] = 32'hFFFFFFFF;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      send_request(stim_rows[i].func, stim_rows[i].sector, stim_rows[i].typed,
                   stim_rows[i].reply);

    // Mostly reads and writes over a pool a bit larger than the cache
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_requested = 1'b1;
      steady_run = (n >= 250 && n < 290);
      if (n == 200) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cache_replies.size() > 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 2) func = FUNC_FLUSH;
      else if (r < 4) func = FUNC_UNKNOWN;
      else func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      sector = ($urandom_range(0, 99) < 85) ? sector_pool[$urandom_range(0, 95)]
                                            : $urandom();
      send_request(func, sector, 0, '0);
    end
    steady_run = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain, then watch for stray results
    while (cache_replies.size() > 0) @(posedge clk);
    settle = 4 * SLOTS + 20;
    repeat (settle) @(posedge clk);

    $display("Covered %0d results: %0d hits, %0d evictions, %0d write-backs, %0d flushes.",
             replies_seen, hit_count, evict_count, writeback_count, flush_count);
    if (errors == 0 && cache_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
